[rtl/ring_buffer_deque_macros.svh]
// Assertion helpers for the deque; empty when NO_ASSERTIONS is set.
`ifndef RING_BUFFER_DEQUE_MACROS_SVH
`define RING_BUFFER_DEQUE_MACROS_SVH

`ifndef NO_ASSERTIONS
`define RBD_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("deque check failed");
`define RBD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("deque check failed");
`else
`define RBD_ASSERT_SAME(label, ante, cons)
`define RBD_ASSERT_NEXT(label, ante, cons)
`endif

`endif

[rtl/rbd_pkg.sv]
`default_nettype none
package rbd_pkg;

    localparam int DEFAULT_CAPACITY = 32;
    localparam int DATA_W           = 32;
    localparam int OFFSET_W         = 5;
    localparam int KIND_W           = 3;
    localparam int STATUS_W         = 2;
    localparam int IN_TDATA_W       = 40;   // value, offset, zero pad

    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH_BACK  = 3'd0,
        KIND_PUSH_FRONT = 3'd1,
        KIND_POP_FRONT  = 3'd2,
        KIND_POP_BACK   = 3'd3,
        KIND_ROTATE     = 3'd4,
        KIND_ROTATE_REV = 3'd5,
        KIND_SWAP       = 3'd6,
        KIND_READ       = 3'd7
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FEW   = 2'd1,
        ST_FULL  = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SWAP_B,
        S_FINISH,
        S_SWAP_W
    } state_t;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } mem_ctl_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] data;
        status_t                  status;
    } result_t;

endpackage
`default_nettype wire

[rtl/rbd_mem.sv]
`default_nettype none
// Simple dual-port store, one write and one registered read per cycle.
module rbd_mem #(
    parameter int DEPTH  = rbd_pkg::DEFAULT_CAPACITY,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic                          aclk,
    input  wire rbd_pkg::mem_ctl_t             ctl,
    input  wire logic [ADDR_W-1:0]             wr_addr,
    input  wire logic [rbd_pkg::DATA_W-1:0]    wr_data,
    input  wire logic [ADDR_W-1:0]             rd_addr,
    output logic      [rbd_pkg::DATA_W-1:0]    rd_data_reg
);
    import rbd_pkg::*;

    logic [DATA_W-1:0] store [DEPTH];

    always_ff @(posedge aclk) begin
        if (ctl.wr_en) begin
            store[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.rd_en) begin
            rd_data_reg <= store[rd_addr];
        end
    end

endmodule
`default_nettype wire

[rtl/rbd_ctrl.sv]
`default_nettype none
// Request sequencer: pointers, fill count and store access ordering.
module rbd_ctrl #(
    parameter int CAPACITY = rbd_pkg::DEFAULT_CAPACITY,
    parameter int PTR_W    = $clog2(CAPACITY),
    parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire rbd_pkg::kind_t                in_kind,
    input  wire logic [rbd_pkg::DATA_W-1:0]    in_value,
    input  wire logic [rbd_pkg::OFFSET_W-1:0]  in_offset,
    input  wire logic                          out_free,
    output logic                               res_valid,
    output rbd_pkg::result_t                   res,
    output logic [CNT_W-1:0]                   res_count,
    output rbd_pkg::mem_ctl_t                  mem_ctl,
    output logic [PTR_W-1:0]                   mem_wr_addr,
    output logic [rbd_pkg::DATA_W-1:0]         mem_wr_data,
    output logic [PTR_W-1:0]                   mem_rd_addr,
    input  wire logic [rbd_pkg::DATA_W-1:0]    mem_rd_data
);
    import rbd_pkg::*;

    localparam int SUM_W = ((PTR_W > OFFSET_W) ? PTR_W : OFFSET_W) + 1;
    localparam int CMP_W = (CNT_W > OFFSET_W) ? CNT_W : OFFSET_W;
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(CAPACITY - 1);

    state_t            state_reg, state_next;
    logic [PTR_W-1:0]  head_reg, head_next;
    logic [PTR_W-1:0]  tail_reg, tail_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    kind_t             kind_reg, kind_next;
    logic [DATA_W-1:0] value_reg, value_next;
    status_t           status_reg, status_next;
    logic [DATA_W-1:0] hold_reg, hold_next;

    logic [PTR_W-1:0]  head_inc, head_dec, tail_inc, tail_dec, offset_addr;
    logic [SUM_W-1:0]  offset_sum;
    status_t           in_status;
    logic              is_full, is_empty;

    assign head_inc = (head_reg == LAST_PTR) ? '0 : head_reg + 1'b1;
    assign head_dec = (head_reg == '0) ? LAST_PTR : head_reg - 1'b1;
    assign tail_inc = (tail_reg == LAST_PTR) ? '0 : tail_reg + 1'b1;
    assign tail_dec = (tail_reg == '0) ? LAST_PTR : tail_reg - 1'b1;

    // head + offset stays below twice the capacity whenever the read is allowed
    assign offset_sum  = SUM_W'(head_reg) + SUM_W'(in_offset);
    assign offset_addr = (offset_sum >= SUM_W'(CAPACITY))
                       ? PTR_W'(offset_sum - SUM_W'(CAPACITY))
                       : PTR_W'(offset_sum);

    assign is_full  = (count_reg == CNT_W'(CAPACITY));
    assign is_empty = (count_reg == '0);

    always_comb begin
        in_status = ST_OK;
        case (in_kind)
            KIND_PUSH_BACK, KIND_PUSH_FRONT: begin
                if (is_full) in_status = ST_FULL;
            end
            KIND_POP_FRONT, KIND_POP_BACK, KIND_ROTATE, KIND_ROTATE_REV: begin
                if (is_empty) in_status = ST_FEW;
            end
            KIND_SWAP: begin
                if (count_reg < CNT_W'(2)) in_status = ST_FEW;
            end
            default: begin
                if (CMP_W'(in_offset) >= CMP_W'(count_reg)) in_status = ST_RANGE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg   <= kind_next;
        value_reg  <= value_next;
        status_reg <= status_next;
        hold_reg   <= hold_next;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    state_next = (in_kind == KIND_SWAP && in_status == ST_OK)
                               ? S_SWAP_B : S_FINISH;
                end
            end
            S_SWAP_B: state_next = S_FINISH;
            S_FINISH: begin
                if (out_free) begin
                    state_next = (kind_reg == KIND_SWAP && status_reg == ST_OK)
                               ? S_SWAP_W : S_IDLE;
                end
            end
            S_SWAP_W: state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // datapath and store control
    always_comb begin
        in_ready      = (state_reg == S_IDLE);
        mem_ctl       = '0;
        mem_rd_addr   = head_reg;
        mem_wr_addr   = tail_reg;
        mem_wr_data   = value_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        count_next    = count_reg;
        kind_next     = kind_reg;
        value_next    = value_reg;
        status_next   = status_reg;
        hold_next     = hold_reg;
        res_valid     = 1'b0;
        res.data      = '0;
        res.status    = status_reg;
        res_count     = count_reg;

        case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    kind_next   = in_kind;
                    value_next  = in_value;
                    status_next = in_status;
                    mem_ctl.rd_en = 1'b1;
                    case (in_kind)
                        KIND_POP_BACK, KIND_ROTATE_REV: mem_rd_addr = tail_dec;
                        KIND_READ:                      mem_rd_addr = offset_addr;
                        default:                        mem_rd_addr = head_reg;
                    endcase
                end
            end
            S_SWAP_B: begin
                // front word arrives, fetch the second one
                hold_next     = mem_rd_data;
                mem_ctl.rd_en = 1'b1;
                mem_rd_addr   = head_inc;
            end
            S_FINISH: begin
                if (out_free) begin
                    res_valid = 1'b1;
                    if (status_reg == ST_OK) begin
                        case (kind_reg)
                            KIND_PUSH_BACK: begin
                                mem_ctl.wr_en = 1'b1;
                                mem_wr_addr   = tail_reg;
                                tail_next     = tail_inc;
                                count_next    = count_reg + 1'b1;
                            end
                            KIND_PUSH_FRONT: begin
                                mem_ctl.wr_en = 1'b1;
                                mem_wr_addr   = head_dec;
                                head_next     = head_dec;
                                count_next    = count_reg + 1'b1;
                            end
                            KIND_POP_FRONT: begin
                                res.data   = mem_rd_data;
                                head_next  = head_inc;
                                count_next = count_reg - 1'b1;
                            end
                            KIND_POP_BACK: begin
                                res.data   = mem_rd_data;
                                tail_next  = tail_dec;
                                count_next = count_reg - 1'b1;
                            end
                            KIND_ROTATE: begin
                                res.data      = mem_rd_data;
                                mem_ctl.wr_en = 1'b1;
                                mem_wr_addr   = tail_reg;
                                mem_wr_data   = mem_rd_data;
                                head_next     = head_inc;
                                tail_next     = tail_inc;
                            end
                            KIND_ROTATE_REV: begin
                                res.data      = mem_rd_data;
                                mem_ctl.wr_en = 1'b1;
                                mem_wr_addr   = head_dec;
                                mem_wr_data   = mem_rd_data;
                                head_next     = head_dec;
                                tail_next     = tail_dec;
                            end
                            KIND_SWAP: begin
                                // second word into the front slot
                                mem_ctl.wr_en = 1'b1;
                                mem_wr_addr   = head_reg;
                                mem_wr_data   = mem_rd_data;
                            end
                            default: begin
                                res.data = mem_rd_data;
                            end
                        endcase
                    end
                    res_count = count_next;
                end
            end
            S_SWAP_W: begin
                mem_ctl.wr_en = 1'b1;
                mem_wr_addr   = head_inc;
                mem_wr_data   = hold_reg;
            end
            default: ;
        endcase
    end

endmodule
`default_nettype wire

[rtl/ring_buffer_deque.sv]
// Order: an accepted item is read from the store in idle, and its result is
//   registered from the finish step; a swap reads its second word in between.
// Flow: items are taken one at a time, a swap adding a second read and a
//   second write; a result left waiting in the output register holds the
//   sequencer in its finish step until the sink takes it.
// Reset (aresetn low, synchronous): pointers, fill count, sequencer and the
//   output valid flag clear; the store itself is not cleared.
`default_nettype none
`include "ring_buffer_deque_macros.svh"
module ring_buffer_deque #(
    parameter int CAPACITY = rbd_pkg::DEFAULT_CAPACITY,
    parameter int PTR_W    = $clog2(CAPACITY),
    parameter int CNT_W    = $clog2(CAPACITY + 1),
    parameter int OUT_W    = ((rbd_pkg::DATA_W + CNT_W + 7) / 8) * 8
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // input item
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [rbd_pkg::IN_TDATA_W-1:0]  s_tdata,   // value[31:0], offset[36:32]
    input  wire logic [rbd_pkg::KIND_W-1:0]      s_tuser,   // kind[2:0]
    // result item
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [OUT_W-1:0]                     m_tdata,   // data[31:0], count above it
    output logic [rbd_pkg::STATUS_W-1:0]         m_tuser    // status[1:0]
);
    import rbd_pkg::*;

    logic              in_ready;
    logic              res_valid;
    result_t           res;
    logic [CNT_W-1:0]  res_count;
    mem_ctl_t          mem_ctl;
    logic [PTR_W-1:0]  mem_wr_addr, mem_rd_addr;
    logic [DATA_W-1:0] mem_wr_data, mem_rd_data;

    // output register: holds one finished item until the sink takes it
    logic              m_valid_reg;
    logic [DATA_W-1:0] m_data_reg;
    logic [CNT_W-1:0]  m_count_reg;
    status_t           m_status_reg;
    logic              out_free;

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = in_ready;

    rbd_ctrl #(
        .CAPACITY (CAPACITY),
        .PTR_W    (PTR_W),
        .CNT_W    (CNT_W)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (in_ready),
        .in_kind     (kind_t'(s_tuser)),
        .in_value    (s_tdata[DATA_W-1:0]),
        .in_offset   (s_tdata[DATA_W+OFFSET_W-1:DATA_W]),
        .out_free    (out_free),
        .res_valid   (res_valid),
        .res         (res),
        .res_count   (res_count),
        .mem_ctl     (mem_ctl),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data)
    );

    rbd_mem #(
        .DEPTH  (CAPACITY),
        .ADDR_W (PTR_W)
    ) u_mem (
        .aclk        (aclk),
        .ctl         (mem_ctl),
        .wr_addr     (mem_wr_addr),
        .wr_data     (mem_wr_data),
        .rd_addr     (mem_rd_addr),
        .rd_data_reg (mem_rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // payload loads only when the sequencer hands over a finished item
    always_ff @(posedge aclk) begin
        if (res_valid) begin
            m_data_reg   <= res.data;
            m_count_reg  <= res_count;
            m_status_reg <= res.status;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = OUT_W'({m_count_reg, m_data_reg});
    assign m_tuser  = m_status_reg;

    // checks
    `RBD_ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready)
    `RBD_ASSERT_SAME(a_count_bound, m_tvalid, m_count_reg <= CNT_W'(CAPACITY))
    `RBD_ASSERT_SAME(a_refused_zero, m_tvalid && (m_status_reg != ST_OK), m_data_reg == '0)
    `RBD_ASSERT_SAME(a_full_count, m_tvalid && (m_status_reg == ST_FULL),
                     m_count_reg == CNT_W'(CAPACITY))

endmodule
`default_nettype wire
